[design/tgu_pkg.sv]
`timescale 1ns / 1ps

package tgu_pkg;

  // value format and matrix geometry
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned DIM     = 8;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned ADDR_W  = 2 * IDX_W;
  localparam int unsigned CNT_W   = IDX_W + 1;

  // shared multiplier and accumulators
  localparam int unsigned MUL_W  = VALUE_W + 1;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned ACC_W  = 2 * VALUE_W + IDX_W;
  localparam int unsigned RES_W  = 104;

  // operation codes of an input beat
  localparam logic [1:0] OPER_LOAD_A  = 2'd0;
  localparam logic [1:0] OPER_LOAD_B  = 2'd1;
  localparam logic [1:0] OPER_LOAD_C  = 2'd2;
  localparam logic [1:0] OPER_COMPUTE = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRA   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRB   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 3'd6;

  typedef enum logic [2:0] {
    OP_MAC,
    OP_BETA,
    OP_ACC0,
    OP_ACC1,
    OP_ACC2
  } mac_op_e;

  typedef struct packed {
    logic    clr;
    logic    vld;
    mac_op_e op;
  } mac_ctrl_t;

endpackage

[design/tgu_store.sv]
`timescale 1ns / 1ps

module tgu_store import tgu_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  waddr_i,
  input  logic [VALUE_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  output logic [VALUE_W-1:0] rdata_o
);

  logic [VALUE_W-1:0] mem_q [DIM*DIM];
  logic [VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/tgu_mac.sv]
`timescale 1ns / 1ps

module tgu_mac import tgu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mac_ctrl_t          ctrl_i,
  input  logic [VALUE_W-1:0] a_i,
  input  logic [VALUE_W-1:0] b_i,
  input  logic [VALUE_W-1:0] c_i,
  input  logic [VALUE_W-1:0] alpha_i,
  input  logic [VALUE_W-1:0] beta_i,
  output logic [VALUE_W-1:0] rnd_o
);

  localparam logic [RES_W-1:0] HALF = {{(RES_W-32){1'b0}}, 32'h8000_0000};

  logic signed [MUL_W-1:0]  opx, opy;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     pv_q;
  mac_op_e                  pop_q;
  logic [ACC_W-1:0]         acc_q;
  logic [RES_W-1:0]         res_q;
  logic [RES_W-1:0]         pext;
  logic [RES_W-1:0]         rx;
  logic [RES_W-33:0]        ry;

  // operand select for the one multiplier
  always_comb begin
    unique case (ctrl_i.op)
      OP_MAC: begin
        opx = {a_i[VALUE_W-1], a_i};
        opy = {b_i[VALUE_W-1], b_i};
      end
      OP_BETA: begin
        opx = {c_i[VALUE_W-1], c_i};
        opy = {beta_i[VALUE_W-1], beta_i};
      end
      OP_ACC0: begin
        opx = {1'b0, acc_q[31:0]};
        opy = {alpha_i[VALUE_W-1], alpha_i};
      end
      OP_ACC1: begin
        opx = {1'b0, acc_q[63:32]};
        opy = {alpha_i[VALUE_W-1], alpha_i};
      end
      OP_ACC2: begin
        opx = {{(MUL_W-(ACC_W-64)){acc_q[ACC_W-1]}}, acc_q[ACC_W-1:64]};
        opy = {alpha_i[VALUE_W-1], alpha_i};
      end
      default: begin
        opx = '0;
        opy = '0;
      end
    endcase
  end

  assign prod_d = opx * opy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      pop_q <= OP_MAC;
    end else begin
      pv_q  <= ctrl_i.vld;
      pop_q <= ctrl_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign pext = {{(RES_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // accumulate stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      acc_q <= '0;
      res_q <= '0;
    end else if (pv_q) begin
      unique case (pop_q)
        OP_MAC:  acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
        OP_BETA: res_q <= res_q + (pext << 16);
        OP_ACC0: res_q <= res_q + pext;
        OP_ACC1: res_q <= res_q + (pext << 32);
        OP_ACC2: res_q <= res_q + (pext << 64);
        default: res_q <= res_q;
      endcase
    end
  end

  // round half up to Q16.16 and saturate
  assign rx = res_q + HALF;
  assign ry = rx[RES_W-1:32];

  always_comb begin
    if ((&ry[RES_W-33:VALUE_W-1]) || !(|ry[RES_W-33:VALUE_W-1])) begin
      rnd_o = ry[VALUE_W-1:0];
    end else if (ry[RES_W-33]) begin
      rnd_o = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      rnd_o = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

endmodule

[design/triangular_gemm_update_unit.sv]
`timescale 1ns / 1ps

// channel  | direction | handshake              | payload
// in       | to block  | in_valid_i/in_stall_o  | operation, row_index, col_index, elem_value
// out      | from block| out_valid_o/out_stall_i| out_row, out_col, out_value, last_of_run
// cfg      | to block  | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
// a load beat is written straight into its store
// a compute beat walks the chosen triangle; for each element the single 33x33
// multiplier does the beta term, k products and three alpha partials one after
// another, then the pipeline drains and the sum is rounded
// the input is stalled for the whole walk; a stalled output holds the walk
// in its rounding step until the beat leaves
// reset clears control and restores the register defaults; stores are not cleared

module triangular_gemm_update_unit import tgu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VALUE_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           operation_i,
  input  logic [IDX_W-1:0]     row_index_i,
  input  logic [IDX_W-1:0]     col_index_i,
  input  logic [VALUE_W-1:0]   elem_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IDX_W-1:0]     out_row_o,
  output logic [IDX_W-1:0]     out_col_o,
  output logic [VALUE_W-1:0]   out_value_o,
  output logic                 last_of_run_o
);

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLR  = 4'd1;
  localparam logic [3:0] ST_MAC  = 4'd2;
  localparam logic [3:0] ST_WAIT = 4'd3;
  localparam logic [3:0] ST_AL0  = 4'd4;
  localparam logic [3:0] ST_AL1  = 4'd5;
  localparam logic [3:0] ST_AL2  = 4'd6;
  localparam logic [3:0] ST_W2   = 4'd7;
  localparam logic [3:0] ST_W3   = 4'd8;
  localparam logic [3:0] ST_RND  = 4'd9;

  // configuration registers
  logic               lower_q, tra_q, trb_q;
  logic [CNT_W-1:0]   order_q, inner_q;
  logic [VALUE_W-1:0] alpha_q, beta_q;

  logic [3:0]         state_q, state_d;
  logic [IDX_W-1:0]   i_q, i_d, j_q, j_d, l_q, l_d;
  logic [CNT_W-1:0]   n_q, n_d, k_q, k_d;
  logic [CNT_W-1:0]   n_clamp, k_clamp, nm1, km1;

  // issued op, registered to line up with the store read data
  logic               issue_v;
  mac_op_e            issue_op;
  logic               op_v_q;
  mac_op_e            op_q;
  mac_ctrl_t          mac_ctrl;

  logic               in_acc, fire, last_elem, out_free;
  logic [VALUE_W-1:0] a_rd, b_rd, c_rd, rnd;
  logic [ADDR_W-1:0]  a_raddr, b_raddr, c_raddr, ld_addr, c_waddr;
  logic               c_we;
  logic [VALUE_W-1:0] c_wdata;

  logic               out_v_q, out_v_d, out_last_q;
  logic [IDX_W-1:0]   out_row_q, out_col_q;
  logic [VALUE_W-1:0] out_val_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ld_addr    = {row_index_i, col_index_i};

  // order and length are bounded by the 8x8 stores
  assign n_clamp = (order_q > CNT_W'(DIM)) ? CNT_W'(DIM) : order_q;
  assign k_clamp = (inner_q > CNT_W'(DIM)) ? CNT_W'(DIM) : inner_q;
  assign nm1     = n_q - CNT_W'(1);
  assign km1     = k_q - CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= 1'b0;
      tra_q   <= 1'b0;
      trb_q   <= 1'b0;
      order_q <= CNT_W'(DIM);
      inner_q <= CNT_W'(DIM);
      alpha_q <= 32'h0001_0000;
      beta_q  <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LOWER: lower_q <= cfg_wdata_i[0];
        CFG_TRA:   tra_q   <= cfg_wdata_i[0];
        CFG_TRB:   trb_q   <= cfg_wdata_i[0];
        CFG_ORDER: order_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_INNER: inner_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_ALPHA: alpha_q <= cfg_wdata_i;
        CFG_BETA:  beta_q  <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  // store addressing: op(A)(i,l) and op(B)(l,j)
  assign a_raddr = tra_q ? {l_q, i_q} : {i_q, l_q};
  assign b_raddr = trb_q ? {j_q, l_q} : {l_q, j_q};
  assign c_raddr = {i_q, j_q};

  // last element of either triangle sits on the corner
  assign last_elem = (i_q == nm1[IDX_W-1:0]) && (j_q == nm1[IDX_W-1:0]);
  assign out_free  = !out_v_q || !out_stall_i;
  assign fire      = (state_q == ST_RND) && out_free;

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    l_d      = l_q;
    n_d      = n_q;
    k_d      = k_q;
    issue_v  = 1'b0;
    issue_op = OP_MAC;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && operation_i == OPER_COMPUTE && n_clamp != '0) begin
          state_d = ST_CLR;
          n_d     = n_clamp;
          k_d     = k_clamp;
          i_d     = '0;
          j_d     = '0;
        end
      end
      ST_CLR: begin
        // old C times beta goes first, it does not wait on the products
        issue_v  = 1'b1;
        issue_op = OP_BETA;
        l_d      = '0;
        state_d  = (k_q == '0) ? ST_WAIT : ST_MAC;
      end
      ST_MAC: begin
        issue_v  = 1'b1;
        issue_op = OP_MAC;
        if ({1'b0, l_q} == km1) begin
          state_d = ST_WAIT;
        end else begin
          l_d = l_q + IDX_W'(1);
        end
      end
      ST_WAIT: state_d = ST_AL0;
      ST_AL0: begin
        issue_v  = 1'b1;
        issue_op = OP_ACC0;
        state_d  = ST_AL1;
      end
      ST_AL1: begin
        issue_v  = 1'b1;
        issue_op = OP_ACC1;
        state_d  = ST_AL2;
      end
      ST_AL2: begin
        issue_v  = 1'b1;
        issue_op = OP_ACC2;
        state_d  = ST_W2;
      end
      ST_W2: state_d = ST_W3;
      ST_W3: state_d = ST_RND;
      ST_RND: begin
        if (out_free) begin
          if (last_elem) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_CLR;
            // column-major walk over the triangle
            if (lower_q) begin
              if (i_q == nm1[IDX_W-1:0]) begin
                j_d = j_q + IDX_W'(1);
                i_d = j_q + IDX_W'(1);
              end else begin
                i_d = i_q + IDX_W'(1);
              end
            end else begin
              if (i_q == j_q) begin
                j_d = j_q + IDX_W'(1);
                i_d = '0;
              end else begin
                i_d = i_q + IDX_W'(1);
              end
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      l_q     <= '0;
      n_q     <= '0;
      k_q     <= '0;
      op_v_q  <= 1'b0;
      op_q    <= OP_MAC;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      l_q     <= l_d;
      n_q     <= n_d;
      k_q     <= k_d;
      op_v_q  <= issue_v;
      op_q    <= issue_op;
      out_v_q <= out_v_d;
    end
  end

  assign mac_ctrl.clr = (state_q == ST_CLR);
  assign mac_ctrl.vld = op_v_q;
  assign mac_ctrl.op  = op_q;

  // stores: loads in idle, C write-back when a beat is produced
  assign c_we    = (in_acc && operation_i == OPER_LOAD_C) || fire;
  assign c_waddr = fire ? c_raddr : ld_addr;
  assign c_wdata = fire ? rnd : elem_value_i;

  tgu_store u_a_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && operation_i == OPER_LOAD_A),
    .waddr_i (ld_addr),
    .wdata_i (elem_value_i),
    .raddr_i (a_raddr),
    .rdata_o (a_rd)
  );

  tgu_store u_b_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && operation_i == OPER_LOAD_B),
    .waddr_i (ld_addr),
    .wdata_i (elem_value_i),
    .raddr_i (b_raddr),
    .rdata_o (b_rd)
  );

  tgu_store u_c_store (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rd)
  );

  tgu_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .a_i     (a_rd),
    .b_i     (b_rd),
    .c_i     (c_rd),
    .alpha_i (alpha_q),
    .beta_i  (beta_q),
    .rnd_o   (rnd)
  );

  // output register
  assign out_v_d = fire || (out_v_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_row_q  <= i_q;
      out_col_q  <= j_q;
      out_val_q  <= rnd;
      out_last_q <= last_elem;
    end
  end

  assign out_valid_o   = out_v_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign out_value_o   = out_val_q;
  assign last_of_run_o = out_last_q;

  // the final beat of a walk lies on the diagonal
  a_last_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_run_o |-> out_row_o == out_col_o)
    else $error("last beat off the diagonal");

  // beats stay inside the selected triangle
  a_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !lower_q |-> out_row_o <= out_col_o)
    else $error("beat outside upper triangle");

  a_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lower_q |-> out_row_o >= out_col_o)
    else $error("beat outside lower triangle");

  // multiplier pipeline is empty when the sum is rounded
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RND |-> !mac_ctrl.vld)
    else $error("rounding with ops in flight");

endmodule
